### sv/sqw_pkg.sv
`default_nettype none

package sqw_pkg;

  localparam logic [2:0] FuncRead      = 3'd0;
  localparam logic [2:0] FuncWrite     = 3'd1;
  localparam logic [2:0] FuncCycleTick = 3'd2;
  localparam logic [2:0] FuncLenTick   = 3'd3;
  localparam logic [2:0] FuncEnvTick   = 3'd4;
  localparam logic [2:0] FuncSweepTick = 3'd5;

  localparam logic [15:0] AddrSweep = 16'hff10;
  localparam logic [15:0] AddrLen1  = 16'hff11;
  localparam logic [15:0] AddrEnv1  = 16'hff12;
  localparam logic [15:0] AddrPlo1  = 16'hff13;
  localparam logic [15:0] AddrPhi1  = 16'hff14;
  localparam logic [15:0] AddrLen2  = 16'hff16;
  localparam logic [15:0] AddrEnv2  = 16'hff17;
  localparam logic [15:0] AddrPlo2  = 16'hff18;
  localparam logic [15:0] AddrPhi2  = 16'hff19;

  localparam logic [7:0] ReadUnmapped = 8'hff;
  localparam logic [6:0] LenFull      = 7'd64;
  localparam logic [3:0] VolMax       = 4'd15;
  localparam logic [3:0] PaceDefault  = 4'd8;
  localparam logic [4:0] EnvDefault   = 5'd8;

  // 12.5 / 25 / 50 / 75 percent, step 0 in bit 7
  localparam logic [7:0] DutyTable [4] = '{8'h80, 8'h81, 8'he1, 8'h7e};

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [9:0]  cycle_count;
  } sqw_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [3:0] sample;
    logic       channel_on;
  } sqw_out_t;

endpackage

`default_nettype wire

### sv/sqw_chan.sv
`default_nettype none

module sqw_chan (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire sqw_pkg::sqw_in_t item_i,
  output sqw_pkg::sqw_out_t     res_o
);

  logic [7:0]  sweep_q, sweep_d, lendut_q, lendut_d, env_q, env_d;
  logic [7:0]  plo_q, plo_d, phi_q, phi_d;
  logic [15:0] timer_q, timer_d;
  logic [2:0]  duty_q, duty_d;
  logic [6:0]  len_q, len_d;
  logic [4:0]  envcnt_q, envcnt_d;
  logic [3:0]  vol_q, vol_d;
  logic        envact_q, envact_d;
  logic [3:0]  swcnt_q, swcnt_d;
  logic        swact_q, swact_d;
  logic [10:0] shadow_q, shadow_d;
  logic        en_q, en_d;
  logic [3:0]  level_q, level_d;
  logic [7:0]  rdata;

  logic [10:0] per_new;
  logic [15:0] tsub;
  logic        wrap;
  logic [4:0]  envm1;
  logic [3:0]  vol_new;
  logic [2:0]  pace;
  logic [11:0] v0, v1, v2;

  function automatic logic [15:0] reload(input logic [10:0] per);
    logic [11:0] span;
    span = 12'h800 - {1'b0, per};
    return {2'b00, span, 2'b00};
  endfunction

  // bit 11 set means the target passed 2047
  function automatic logic [11:0] sweep_calc(input logic [10:0] sh, input logic [7:0] sw);
    logic [10:0] part;
    part = sh >> sw[2:0];
    return sw[3] ? ({1'b0, sh} - {1'b0, part}) : ({1'b0, sh} + {1'b0, part});
  endfunction

  always_comb begin
    sweep_d  = sweep_q;
    lendut_d = lendut_q;
    env_d    = env_q;
    plo_d    = plo_q;
    phi_d    = phi_q;
    timer_d  = timer_q;
    duty_d   = duty_q;
    len_d    = len_q;
    envcnt_d = envcnt_q;
    vol_d    = vol_q;
    envact_d = envact_q;
    swcnt_d  = swcnt_q;
    swact_d  = swact_q;
    shadow_d = shadow_q;
    en_d     = en_q;
    level_d  = level_q;
    rdata    = 8'h00;

    per_new = {item_i.write_data[2:0], plo_q};
    tsub    = timer_q - {6'b0, item_i.cycle_count};
    wrap    = (tsub == 16'h0000) || tsub[15];
    envm1   = envcnt_q - 5'd1;
    vol_new = vol_q;
    pace    = sweep_q[6:4];
    v0      = sweep_calc(per_new, sweep_q);
    v1      = sweep_calc(shadow_q, sweep_q);
    v2      = sweep_calc(v1[10:0], sweep_q);

    case (item_i.func)
      sqw_pkg::FuncRead: begin
        case (item_i.address)
          sqw_pkg::AddrSweep:                    rdata = sweep_q;
          sqw_pkg::AddrLen1, sqw_pkg::AddrLen2:  rdata = lendut_q;
          sqw_pkg::AddrEnv1, sqw_pkg::AddrEnv2:  rdata = env_q;
          sqw_pkg::AddrPlo1, sqw_pkg::AddrPlo2:  rdata = plo_q;
          sqw_pkg::AddrPhi1, sqw_pkg::AddrPhi2:  rdata = phi_q;
          default:                               rdata = sqw_pkg::ReadUnmapped;
        endcase
      end
      sqw_pkg::FuncWrite: begin
        case (item_i.address)
          sqw_pkg::AddrSweep:                    sweep_d  = item_i.write_data;
          sqw_pkg::AddrLen1, sqw_pkg::AddrLen2:  lendut_d = item_i.write_data;
          sqw_pkg::AddrEnv1, sqw_pkg::AddrEnv2:  env_d    = item_i.write_data;
          sqw_pkg::AddrPlo1, sqw_pkg::AddrPlo2:  plo_d    = item_i.write_data;
          sqw_pkg::AddrPhi1, sqw_pkg::AddrPhi2: begin
            phi_d = item_i.write_data;
            if (item_i.write_data[7]) begin
              en_d     = 1'b1;
              len_d    = (len_q == 7'd0) ? sqw_pkg::LenFull : len_q;
              timer_d  = reload(per_new);
              envact_d = 1'b1;
              envcnt_d = {2'b00, env_q[2:0]};
              vol_d    = env_q[7:4];
              shadow_d = per_new;
              swcnt_d  = (pace != 3'd0) ? {1'b0, pace} : sqw_pkg::PaceDefault;
              swact_d  = 1'b1;
              if (sweep_q[2:0] != 3'd0 && v0[11]) begin
                en_d = 1'b0;
              end
            end
          end
          default: ;
        endcase
      end
      sqw_pkg::FuncCycleTick: begin
        timer_d = wrap ? (reload({phi_q[2:0], plo_q}) + tsub) : tsub;
        duty_d  = wrap ? (duty_q + 3'd1) : duty_q;
        level_d = (en_q && env_q[7:3] != 5'd0) ? vol_q : 4'd0;
        if (!sqw_pkg::DutyTable[lendut_q[7:6]][3'd7 - duty_d]) begin
          level_d = 4'd0;
        end
      end
      sqw_pkg::FuncLenTick: begin
        if (len_q != 7'd0 && phi_q[6]) begin
          len_d = len_q - 7'd1;
          if (len_q == 7'd1) begin
            en_d = 1'b0;
          end
        end
      end
      sqw_pkg::FuncEnvTick: begin
        envcnt_d = envm1;
        if (envm1[4] || envm1 == 5'd0) begin
          envcnt_d = (env_q[2:0] != 3'd0) ? {2'b00, env_q[2:0]} : sqw_pkg::EnvDefault;
          if (env_q[2:0] != 3'd0 && envact_q) begin
            if (env_q[3] && vol_q != sqw_pkg::VolMax) begin
              vol_new = vol_q + 4'd1;
            end else if (!env_q[3] && vol_q != 4'd0) begin
              vol_new = vol_q - 4'd1;
            end
          end
          vol_d = vol_new;
          if (vol_new == 4'd0 || vol_new == sqw_pkg::VolMax) begin
            envact_d = 1'b0;
          end
        end
      end
      sqw_pkg::FuncSweepTick: begin
        if (swcnt_q <= 4'd1) begin
          swcnt_d = (pace != 3'd0) ? {1'b0, pace} : sqw_pkg::PaceDefault;
          if (swact_q && pace != 3'd0) begin
            if (v1[11]) begin
              en_d = 1'b0;
            end else if (sweep_q[2:0] != 3'd0) begin
              shadow_d = v1[10:0];
              plo_d    = v1[7:0];
              phi_d    = {phi_q[7:3], v1[10:8]};
              if (v2[11]) begin
                en_d = 1'b0;
              end
            end
          end
        end else begin
          swcnt_d = swcnt_q - 4'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q  <= '0;
      lendut_q <= '0;
      env_q    <= '0;
      plo_q    <= '0;
      phi_q    <= '0;
      timer_q  <= '0;
      duty_q   <= '0;
      len_q    <= '0;
      envcnt_q <= '0;
      vol_q    <= '0;
      envact_q <= 1'b0;
      swcnt_q  <= '0;
      swact_q  <= 1'b0;
      shadow_q <= '0;
      en_q     <= 1'b0;
      level_q  <= '0;
    end else if (en_i) begin
      sweep_q  <= sweep_d;
      lendut_q <= lendut_d;
      env_q    <= env_d;
      plo_q    <= plo_d;
      phi_q    <= phi_d;
      timer_q  <= timer_d;
      duty_q   <= duty_d;
      len_q    <= len_d;
      envcnt_q <= envcnt_d;
      vol_q    <= vol_d;
      envact_q <= envact_d;
      swcnt_q  <= swcnt_d;
      swact_q  <= swact_d;
      shadow_q <= shadow_d;
      en_q     <= en_d;
      level_q  <= level_d;
    end
  end

  assign res_o.read_data  = rdata;
  assign res_o.sample     = level_d;
  assign res_o.channel_on = en_d;

`ifndef SYNTHESIS
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= sqw_pkg::LenFull)
    else $error("length counter above 64");

  a_env_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    envcnt_q == 5'h1f || envcnt_q <= sqw_pkg::EnvDefault)
    else $error("envelope counter out of range");

  a_sweep_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    swcnt_q <= sqw_pkg::PaceDefault)
    else $error("sweep counter above 8");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(en_q) && $stable(level_q) && $stable(timer_q))
    else $error("channel state moved without a word");
`endif

endmodule

`default_nettype wire

### sv/square_wave_sound_channel.sv
`default_nettype none

// channel | valid      | ready       | payload
// in      | in_valid_i | in_ready_o  | in_word_i  (sqw_pkg::sqw_in_t)
// out     | out_valid_o| out_ready_i | out_word_o (sqw_pkg::sqw_out_t)
//
// One word per clock sustained while out_ready_i is high; the result is valid
// after the input register, then channel state update and result register.
// Reset clears all channel registers and both stage valids.
// A stalled result holds the result register; the input register still takes
// one more word, then in_ready_o drops until the result is taken.

module square_wave_sound_channel (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire sqw_pkg::sqw_in_t in_word_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output sqw_pkg::sqw_out_t     out_word_o
);

  sqw_pkg::sqw_in_t  in_q;
  logic              in_vq;
  logic              adv;
  sqw_pkg::sqw_out_t res;
  sqw_pkg::sqw_out_t out_q;
  logic              out_vq;

  assign adv        = in_vq && (!out_vq || out_ready_i);
  assign in_ready_o = !in_vq || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq <= 1'b0;
    end else if (in_ready_o) begin
      in_vq <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_word_i;
    end
  end

  sqw_chan u_chan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .item_i (in_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq <= 1'b0;
    end else if (adv) begin
      out_vq <= 1'b1;
    end else if (out_ready_i) begin
      out_vq <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vq;
  assign out_word_o  = out_q;

`ifndef SYNTHESIS
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vq && out_vq && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while both stages stalled");

  a_adv_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_o)
    else $error("processed word produced no result");

  a_rose_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_vq))
    else $error("result appeared without an input word");
`endif

endmodule

`default_nettype wire
